// ===== src/smea_pkg.sv =====
// Shared types and constants of the sparse matrix entry accumulator.
package smea_pkg;

    localparam int ROW_W = 13;
    localparam int VAL_W = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ROW_W-1:0] DIM_RESET = 13'd4096;

    // Operation codes of an input item
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SET   = 3'd2,
        OP_GET   = 3'd3,
        OP_READ  = 3'd4,
        OP_CLEAR = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    // Register select, taken from paddr[2]
    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ACT,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_LIST_RD,
        S_LIST_OUT,
        S_EMIT
    } t_state;

    // One stored matrix entry
    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [ROW_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    // Matrix bounds from the register block
    typedef struct packed {
        logic [ROW_W-1:0] row_count;
        logic [ROW_W-1:0] col_count;
    } t_cfg;

endpackage

// ===== src/smea_if.sv =====
// Command and result channel interfaces.
interface smea_cmd_if;
    logic                                    valid;
    logic                                    ready;
    logic [2:0]                              operation;
    logic [smea_pkg::ROW_W-1:0]              row_index;
    logic [smea_pkg::ROW_W-1:0]              col_index;
    logic signed [smea_pkg::VAL_W-1:0]       entry_value;

    modport source (output valid, operation, row_index, col_index, entry_value,
                    input ready);
    modport sink   (input valid, operation, row_index, col_index, entry_value,
                    output ready);
endinterface

interface smea_res_if #(parameter int CNT_W = 7);
    logic                                    valid;
    logic                                    ready;
    logic [smea_pkg::ROW_W-1:0]              out_row;
    logic [smea_pkg::ROW_W-1:0]              out_col;
    logic signed [smea_pkg::VAL_W-1:0]       out_value;
    logic                                    found;
    logic [1:0]                              status;
    logic [CNT_W-1:0]                        entries_held;
    logic                                    last;

    modport source (output valid, out_row, out_col, out_value, found, status,
                    entries_held, last, input ready);
    modport sink   (input valid, out_row, out_col, out_value, found, status,
                    entries_held, last, output ready);
endinterface

// ===== src/sparse_matrix_entry_accumulator.sv =====
// Top level: sequencer over the sorted entry table of a sparse matrix.
// Entries live in one single-port-read memory in row-major order, and one
// item is handled at a time. Every memory step is a read, then a compare or
// write back. An add, subtract, set or get scans the entries from the start
// to find its position; an insert or delete then shifts the entries from
// that position on by one place, and a read-out emits every entry in turn.
// The result side can stall any item. Clear, out-of-range and unknown
// operations skip the scan. The table needs no clearing pass after reset:
// only entries below the fill count are ever read.
module sparse_matrix_entry_accumulator #(
    parameter int CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    smea_cmd_if.sink                     i_cmd,
    smea_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smea_pkg::ADDR_W-1:0]  paddr,
    input  logic [smea_pkg::DATA_W-1:0]  pwdata,
    output logic [smea_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = smea_pkg::ROW_W;
    localparam int VW = smea_pkg::VAL_W;

    smea_pkg::t_cfg   w_cfg;
    smea_pkg::t_state r_state, n_state;

    logic [2:0]           r_op, n_op;
    logic [RW-1:0]        r_row, n_row, r_col, n_col;
    logic signed [VW-1:0] r_val, n_val;
    logic [CW-1:0]        r_idx, n_idx, r_pos, n_pos, r_total, n_total;
    logic                 r_hit, n_hit;
    logic signed [VW-1:0] r_hval, n_hval, r_ins, n_ins;
    logic signed [VW-1:0] r_res_val, n_res_val;
    logic                 r_res_fnd, n_res_fnd;
    logic [1:0]           r_res_st, n_res_st;

    logic                 r_out_vld, n_out_vld;
    logic [RW-1:0]        r_out_row, n_out_row, r_out_col, n_out_col;
    logic signed [VW-1:0] r_out_val, n_out_val;
    logic                 r_out_fnd, n_out_fnd, r_out_last, n_out_last;
    logic [1:0]           r_out_st, n_out_st;
    logic [CW-1:0]        r_out_held, n_out_held;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    smea_pkg::t_entry     mem_wdata, mem_rdata;

    logic                 w_can_emit, w_oor, w_key_ge, w_key_eq;
    logic [CW-1:0]        w_idx_m1;
    logic signed [VW:0]   w_add, w_base;
    logic signed [VW+1:0] w_sum;
    logic signed [VW-1:0] w_sat;
    logic                 w_ovf;

    smea_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    smea_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Position compare, bounds check and saturating sum
    always_comb begin
        w_can_emit = !r_out_vld || o_res.ready;
        w_oor = (r_row == '0) || (r_row > w_cfg.row_count) ||
                (r_col == '0) || (r_col > w_cfg.col_count);
        w_key_ge = {mem_rdata.row, mem_rdata.col} >= {r_row, r_col};
        w_key_eq = {mem_rdata.row, mem_rdata.col} == {r_row, r_col};
        w_idx_m1 = r_idx - CW'(1);
        w_add = (r_op == smea_pkg::OP_SUB) ? -{r_val[VW-1], r_val} : {r_val[VW-1], r_val};
        w_base = r_hit ? {r_hval[VW-1], r_hval} : '0;
        w_sum = {w_base[VW], w_base} + {w_add[VW], w_add};
        w_ovf = 1'b0;
        if (!w_sum[VW+1] && (w_sum[VW:VW-1] != 2'b00)) begin
            w_sat = {1'b0, {(VW-1){1'b1}}};
            w_ovf = 1'b1;
        end else if (w_sum[VW+1] && (w_sum[VW:VW-1] != 2'b11)) begin
            w_sat = {1'b1, {(VW-1){1'b0}}};
            w_ovf = 1'b1;
        end else begin
            w_sat = w_sum[VW-1:0];
        end
    end

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= smea_pkg::S_IDLE;
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_row      <= n_row;
        r_col      <= n_col;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_hit      <= n_hit;
        r_hval     <= n_hval;
        r_ins      <= n_ins;
        r_res_val  <= n_res_val;
        r_res_fnd  <= n_res_fnd;
        r_res_st   <= n_res_st;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_val  <= n_out_val;
        r_out_fnd  <= n_out_fnd;
        r_out_st   <= n_out_st;
        r_out_held <= n_out_held;
        r_out_last <= n_out_last;
    end

    // Sequencer: next state, memory access and result capture
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_row      = r_row;
        n_col      = r_col;
        n_val      = r_val;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_hit      = r_hit;
        n_hval     = r_hval;
        n_ins      = r_ins;
        n_total    = r_total;
        n_res_val  = r_res_val;
        n_res_fnd  = r_res_fnd;
        n_res_st   = r_res_st;
        n_out_vld  = r_out_vld && !o_res.ready;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_val  = r_out_val;
        n_out_fnd  = r_out_fnd;
        n_out_st   = r_out_st;
        n_out_held = r_out_held;
        n_out_last = r_out_last;
        mem_we     = 1'b0;
        mem_waddr  = r_pos[AW-1:0];
        mem_wdata  = '{row: r_row, col: r_col, value: r_val};
        mem_re     = 1'b0;
        mem_raddr  = r_idx[AW-1:0];
        i_cmd.ready = 1'b0;

        unique case (r_state)
            smea_pkg::S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_op    = i_cmd.operation;
                    n_row   = i_cmd.row_index;
                    n_col   = i_cmd.col_index;
                    n_val   = i_cmd.entry_value;
                    n_state = smea_pkg::S_START;
                end
            end
            smea_pkg::S_START: begin
                n_res_val = '0;
                n_res_fnd = 1'b0;
                n_res_st  = smea_pkg::ST_OK;
                n_idx     = '0;
                n_hit     = 1'b0;
                unique case (r_op) inside
                    smea_pkg::OP_READ: begin
                        if (r_total != '0) begin
                            n_state = smea_pkg::S_LIST_RD;
                        end else if (w_can_emit) begin
                            n_out_vld  = 1'b1;
                            n_out_row  = '0;
                            n_out_col  = '0;
                            n_out_val  = '0;
                            n_out_fnd  = 1'b0;
                            n_out_st   = smea_pkg::ST_OK;
                            n_out_held = r_total;
                            n_out_last = 1'b1;
                            n_state    = smea_pkg::S_IDLE;
                        end
                    end
                    smea_pkg::OP_CLEAR: begin
                        n_total = '0;
                        n_state = smea_pkg::S_EMIT;
                    end
                    smea_pkg::OP_ADD, smea_pkg::OP_SUB,
                    smea_pkg::OP_SET, smea_pkg::OP_GET: begin
                        if (w_oor) begin
                            n_res_st = smea_pkg::ST_RANGE;
                            n_state  = smea_pkg::S_EMIT;
                        end else begin
                            n_state = smea_pkg::S_SCAN_RD;
                        end
                    end
                    default: n_state = smea_pkg::S_EMIT;
                endcase
            end
            // Walk the table to the first entry not below the target key
            smea_pkg::S_SCAN_RD: begin
                if (r_idx == r_total) begin
                    n_pos   = r_idx;
                    n_hit   = 1'b0;
                    n_state = smea_pkg::S_ACT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = smea_pkg::S_SCAN_CHK;
                end
            end
            smea_pkg::S_SCAN_CHK: begin
                if (w_key_ge) begin
                    n_pos   = r_idx;
                    n_hit   = w_key_eq;
                    n_hval  = mem_rdata.value;
                    n_state = smea_pkg::S_ACT;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = smea_pkg::S_SCAN_RD;
                end
            end
            // Apply the operation at the located position
            smea_pkg::S_ACT: begin
                n_res_val = '0;
                n_res_fnd = r_hit;
                n_res_st  = smea_pkg::ST_OK;
                n_state   = smea_pkg::S_EMIT;
                if (r_op == smea_pkg::OP_GET) begin
                    n_res_val = r_hit ? r_hval : '0;
                end else if ((r_op == smea_pkg::OP_SET) && (r_val == '0)) begin
                    if (r_hit) begin
                        n_idx   = r_pos + CW'(1);
                        n_state = smea_pkg::S_DEL_RD;
                    end
                end else if (r_hit) begin
                    mem_we = 1'b1;
                    if (r_op == smea_pkg::OP_SET) begin
                        n_res_val = r_val;
                    end else begin
                        mem_wdata.value = w_sat;
                        n_res_val = w_sat;
                        n_res_st  = w_ovf ? smea_pkg::ST_OVF : smea_pkg::ST_OK;
                    end
                end else if (r_total >= CW'(CAPACITY)) begin
                    n_res_st = smea_pkg::ST_FULL;
                end else begin
                    if (r_op == smea_pkg::OP_SET) begin
                        n_ins     = r_val;
                        n_res_val = r_val;
                    end else begin
                        n_ins     = w_sat;
                        n_res_val = w_sat;
                        n_res_st  = w_ovf ? smea_pkg::ST_OVF : smea_pkg::ST_OK;
                    end
                    n_idx   = r_total;
                    n_state = smea_pkg::S_INS_RD;
                end
            end
            // Shift entries up one place, then drop the new entry in
            smea_pkg::S_INS_RD: begin
                if (r_idx == r_pos) begin
                    mem_we          = 1'b1;
                    mem_wdata.value = r_ins;
                    n_total         = r_total + CW'(1);
                    n_state         = smea_pkg::S_EMIT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = w_idx_m1[AW-1:0];
                    n_state   = smea_pkg::S_INS_WR;
                end
            end
            smea_pkg::S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = w_idx_m1;
                n_state   = smea_pkg::S_INS_RD;
            end
            // Shift entries down one place over the deleted one
            smea_pkg::S_DEL_RD: begin
                if (r_idx == r_total) begin
                    n_total = r_total - CW'(1);
                    n_state = smea_pkg::S_EMIT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = smea_pkg::S_DEL_WR;
                end
            end
            smea_pkg::S_DEL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = w_idx_m1[AW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = r_idx + CW'(1);
                n_state   = smea_pkg::S_DEL_RD;
            end
            // Read out every entry in order
            smea_pkg::S_LIST_RD: begin
                mem_re  = 1'b1;
                n_state = smea_pkg::S_LIST_OUT;
            end
            smea_pkg::S_LIST_OUT: begin
                if (w_can_emit) begin
                    n_out_vld  = 1'b1;
                    n_out_row  = mem_rdata.row;
                    n_out_col  = mem_rdata.col;
                    n_out_val  = mem_rdata.value;
                    n_out_fnd  = 1'b1;
                    n_out_st   = smea_pkg::ST_OK;
                    n_out_held = r_total;
                    n_out_last = (r_idx == r_total - CW'(1));
                    n_idx      = r_idx + CW'(1);
                    n_state    = (r_idx == r_total - CW'(1)) ? smea_pkg::S_IDLE
                                                             : smea_pkg::S_LIST_RD;
                end
            end
            // Deliver the single result of the item
            smea_pkg::S_EMIT: begin
                if (w_can_emit) begin
                    n_out_vld  = 1'b1;
                    n_out_row  = r_row;
                    n_out_col  = r_col;
                    n_out_val  = r_res_val;
                    n_out_fnd  = r_res_fnd;
                    n_out_st   = r_res_st;
                    n_out_held = r_total;
                    n_out_last = 1'b1;
                    n_state    = smea_pkg::S_IDLE;
                end
            end
            default: n_state = smea_pkg::S_IDLE;
        endcase
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.out_row      = r_out_row;
    assign o_res.out_col      = r_out_col;
    assign o_res.out_value    = r_out_val;
    assign o_res.found        = r_out_fnd;
    assign o_res.status       = r_out_st;
    assign o_res.entries_held = r_out_held;
    assign o_res.last         = r_out_last;

endmodule

// ===== src/smea_mem.sv =====
// Entry table: one write port, one read port with registered read data.
module smea_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  smea_pkg::t_entry  i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output smea_pkg::t_entry  o_rdata
);

    smea_pkg::t_entry r_mem [DEPTH];
    smea_pkg::t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/smea_cfg.sv =====
// APB register block holding the matrix bounds.
module smea_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smea_pkg::ADDR_W-1:0]  paddr,
    input  logic [smea_pkg::DATA_W-1:0]  pwdata,
    output logic [smea_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output smea_pkg::t_cfg               o_cfg
);

    smea_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count <= smea_pkg::DIM_RESET;
            r_cfg.col_count <= smea_pkg::DIM_RESET;
        end else if (w_wr) begin
            unique case (smea_pkg::t_reg'(paddr[2]))
                smea_pkg::REG_ROWS: r_cfg.row_count <= pwdata[smea_pkg::ROW_W-1:0];
                smea_pkg::REG_COLS: r_cfg.col_count <= pwdata[smea_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (smea_pkg::t_reg'(paddr[2]))
            smea_pkg::REG_ROWS: prdata = {{(smea_pkg::DATA_W-smea_pkg::ROW_W){1'b0}},
                                          r_cfg.row_count};
            smea_pkg::REG_COLS: prdata = {{(smea_pkg::DATA_W-smea_pkg::ROW_W){1'b0}},
                                          r_cfg.col_count};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/smea_chk.sv =====
// Port-level checker for the sparse matrix entry accumulator, bound to the top.
module smea_chk #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [31:0]   out_value,
    input logic          found,
    input logic [1:0]    status,
    input logic [CW-1:0] entries_held,
    input logic          last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(last))
        else $error("result changed while stalled");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // Only read-out results can be non-final, and they report stored entries
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !last |-> found && (status == smea_pkg::ST_OK))
        else $error("non-final result that is not a stored entry");

    // Rejected operations leave nothing behind
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && ((status == smea_pkg::ST_RANGE) || (status == smea_pkg::ST_FULL))
        |-> !found && (out_value == '0) && last)
        else $error("rejected item reports a value");

    // Fill count stays within capacity
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> entries_held <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind sparse_matrix_entry_accumulator smea_chk #(
    .CAPACITY (CAPACITY),
    .CW       ($clog2(CAPACITY + 1))
) u_smea_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_cmd.valid),
    .in_ready     (i_cmd.ready),
    .out_valid    (o_res.valid),
    .out_ready    (o_res.ready),
    .out_value    (o_res.out_value),
    .found        (o_res.found),
    .status       (o_res.status),
    .entries_held (o_res.entries_held),
    .last         (o_res.last)
);
